FILE: rtl/core/pgt_pkg.sv
// Shared constants and types for the polar Gaussian transform core.
`timescale 1ns / 1ps
package pgt_pkg;

  // Field widths
  localparam int SW  = 24;            // uniform sample width, Q1.23
  localparam int OW  = 24;            // normal sample width, Q5.19
  localparam int WW  = 2 * (SW - 1);  // fractional bits of w, w < 1
  localparam int PW  = 6;             // leading-one position of w
  localparam int LF  = 30;            // log2 mantissa fraction bits
  localparam int MW  = LF + 1;        // mantissa register width
  localparam int NLW = LF + PW;       // -log2 w, Q6.30
  localparam int LW  = 32;            // L = -2 ln w, Q7.25
  localparam int DS  = 32;            // ratio quotient bits
  localparam int TW  = 45;            // t = r * L >> 19
  localparam int QW  = 23;            // square root width
  localparam int XW  = 2 * QW;        // padded radicand width
  localparam int RMW = QW + 3;        // root remainder width

  localparam logic [MW-1:0] TWO_LN2_Q30 = 31'd1488522236;

  // Pipeline depths
  localparam int LOG_LAT = LF + 4;        // leading one, normalize, squarings, sub, mult
  localparam int T_PROD  = LOG_LAT + 1;   // product stage index
  localparam int T_LAST  = T_PROD + QW;   // last root stage index

  // Queue between front and back
  localparam int QD  = 4;
  localparam int QAW = 2;

  // Pair that passed the acceptance test
  typedef struct packed {
    logic [WW-1:0] sq_a;
    logic [WW-1:0] sq_b;
    logic [WW-1:0] w;
    logic          neg_a;
    logic          neg_b;
    logic          keep;
  } pgt_item_t;

  // Per-item flags carried along the back pipeline
  typedef struct packed {
    logic neg_a;
    logic neg_b;
    logic keep;
    logic full_a;
    logic full_b;
  } pgt_side_t;

endpackage

FILE: rtl/core/pgt_front.sv
// Front end: takes uniform pairs, squares them and drops rejected pairs.
`timescale 1ns / 1ps
module pgt_front
  import pgt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [SW-1:0] uniform_a,
  input  logic [SW-1:0] uniform_b,
  input  logic          keep_second,
  output logic          push,
  output pgt_item_t     push_item,
  input  logic          q_full
);

  logic              v_r;
  logic [2*SW-1:0]   sq_a_r, sq_b_r;
  logic              neg_a_r, neg_b_r, keep_r;
  logic [SW-1:0]     mag_a, mag_b;
  logic [2*SW:0]     w_sum;
  logic              reject;
  logic              free;

  // magnitudes of the incoming samples
  assign mag_a = uniform_a[SW-1] ? (~uniform_a + 1'b1) : uniform_a;
  assign mag_b = uniform_b[SW-1] ? (~uniform_b + 1'b1) : uniform_b;

  // acceptance test on the registered squares
  assign w_sum  = {1'b0, sq_a_r} + {1'b0, sq_b_r};
  assign reject = (w_sum == '0) || (w_sum[2*SW:WW] != '0);

  assign free     = !v_r || reject || !q_full;
  assign in_ready = free;
  assign push     = v_r && !reject && !q_full;

  assign push_item.sq_a  = sq_a_r[WW-1:0];
  assign push_item.sq_b  = sq_b_r[WW-1:0];
  assign push_item.w     = w_sum[WW-1:0];
  assign push_item.neg_a = neg_a_r;
  assign push_item.neg_b = neg_b_r;
  assign push_item.keep  = keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (free) begin
      v_r <= in_valid;
    end
  end

  // squares, one multiplier per sample
  always_ff @(posedge clk) begin
    if (free && in_valid) begin
      sq_a_r  <= mag_a * mag_a;
      sq_b_r  <= mag_b * mag_b;
      neg_a_r <= uniform_a[SW-1];
      neg_b_r <= uniform_b[SW-1];
      keep_r  <= keep_second;
    end
  end

endmodule

FILE: rtl/core/pgt_queue.sv
// Short queue between the front end and the back pipeline.
`timescale 1ns / 1ps
module pgt_queue
  import pgt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pgt_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output pgt_item_t head_item
);

  pgt_item_t        mem [0:QD-1];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_pop;

  assign full       = (count_r == (QAW+1)'(QD));
  assign head_valid = (count_r != '0);
  assign head_item  = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/core/pgt_log.sv
// Pipelined -2 ln w: leading one, normalize, 30 squaring stages, scale.
`timescale 1ns / 1ps
module pgt_log
  import pgt_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [WW-1:0] w,
  output logic [LW-1:0] l_out
);

  logic [PW-1:0]  p_r;
  logic [WW-1:0]  w1_r;
  logic [PW-1:0]  p_comb;
  logic [MW-1:0]  m_comb;
  logic [MW-1:0]  m_r    [0:LF];
  logic [LF-1:0]  frac_r [0:LF];
  logic [PW-1:0]  ep_r   [0:LF];
  logic [NLW-1:0] nl_r;
  logic [LW+MW-1:0] prod;
  logic [LW-1:0]  l_r;

  // leading-one position
  always_comb begin
    p_comb = '0;
    for (int i = 0; i < WW; i++) begin
      if (w[i]) begin
        p_comb = PW'(i);
      end
    end
  end

  // mantissa into [1,2) as Q1.30
  always_comb begin
    logic [WW-1:0] shifted;
    shifted = '0;
    if (p_r > PW'(LF)) begin
      shifted = w1_r >> (p_r - PW'(LF));
    end else begin
      shifted = w1_r << (PW'(LF) - p_r);
    end
    m_comb = shifted[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r       <= p_comb;
      w1_r      <= w;
      m_r[0]    <= m_comb;
      frac_r[0] <= '0;
      ep_r[0]   <= PW'(WW) - p_r;
    end
  end

  // one fraction bit per squaring stage
  for (genvar k = 1; k <= LF; k++) begin : g_sq
    logic [2*MW-1:0] sq_full;
    logic [MW:0]     sq;
    assign sq_full = m_r[k-1] * m_r[k-1];
    assign sq      = sq_full[2*MW-1:LF];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k]    <= sq[MW] ? sq[MW:1] : sq[MW-1:0];
        frac_r[k] <= {frac_r[k-1][LF-2:0], sq[MW]};
        ep_r[k]   <= ep_r[k-1];
      end
    end
  end

  // -log2 w, then times 2 ln 2
  assign prod = nl_r[NLW-1:4] * TWO_LN2_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      nl_r <= {ep_r[LF], {LF{1'b0}}} - {{PW{1'b0}}, frac_r[LF]};
      l_r  <= prod[LW+LF:LF+1];
    end
  end

  assign l_out = l_r;

endmodule

FILE: rtl/core/pgt_back.sv
// Back pipeline: log, two ratio dividers, product, two square roots, output.
`timescale 1ns / 1ps
module pgt_back
  import pgt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  pgt_item_t     head_item,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [OW-1:0] normal_a,
  output logic [OW-1:0] normal_b,
  output logic          second_valid
);

  logic            adv;
  logic            vld_r [0:T_LAST];
  pgt_side_t       sd_r  [0:T_LAST];
  pgt_item_t       b0_r;
  logic [LW-1:0]   l_val;

  // divider stages
  logic [WW-1:0]   rem_a_r [1:DS];
  logic [WW-1:0]   rem_b_r [1:DS];
  logic [WW-1:0]   den_r   [1:DS];
  logic [DS-1:0]   q_a_r   [1:DS];
  logic [DS-1:0]   q_b_r   [1:DS];
  logic [DS-1:0]   qa_d1_r, qa_d2_r, qb_d1_r, qb_d2_r;

  // product and root stages
  logic [TW-1:0]   t_a_r, t_b_r;
  logic [XW-1:0]   x_a_r [T_PROD:T_LAST];
  logic [XW-1:0]   x_b_r [T_PROD:T_LAST];
  logic [RMW-1:0]  rm_a_r [T_PROD:T_LAST];
  logic [RMW-1:0]  rm_b_r [T_PROD:T_LAST];
  logic [QW-1:0]   rt_a_r [T_PROD:T_LAST];
  logic [QW-1:0]   rt_b_r [T_PROD:T_LAST];

  logic            out_valid_r;
  logic [OW-1:0]   normal_a_r, normal_b_r;
  logic            second_valid_r;

  // whole pipeline moves when the output slot is free or taken
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && head_valid;

  // one restoring step of floor(num * 2^32 / den)
  function automatic logic [WW:0] div_step(input logic [WW-1:0] rem,
                                           input logic [WW-1:0] den);
    logic [WW:0] r2;
    r2 = {rem, 1'b0};
    if (r2 >= {1'b0, den}) begin
      div_step = {r2[WW-1:0] - den, 1'b1};
    end else begin
      div_step = {r2[WW-1:0], 1'b0};
    end
  endfunction

  // one digit of the integer square root: {remainder, root}
  function automatic logic [RMW+QW-1:0] root_step(input logic [RMW-1:0] rem,
                                                  input logic [QW-1:0]  root,
                                                  input logic [1:0]     dig);
    logic [RMW+1:0] r2;
    logic [RMW+1:0] trial;
    r2    = {rem, dig};
    trial = {{(RMW-QW){1'b0}}, root, 2'b01};
    if (r2 >= trial) begin
      root_step = {RMW'(r2 - trial), root[QW-2:0], 1'b1};
    end else begin
      root_step = {RMW'(r2), root[QW-2:0], 1'b0};
    end
  endfunction

  // valid and flag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= T_LAST; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= head_valid;
      for (int i = 1; i <= T_LAST; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_r            <= head_item;
      sd_r[0].neg_a   <= head_item.neg_a;
      sd_r[0].neg_b   <= head_item.neg_b;
      sd_r[0].keep    <= head_item.keep;
      sd_r[0].full_a  <= head_item.sq_a >= head_item.w;
      sd_r[0].full_b  <= head_item.sq_b >= head_item.w;
      for (int i = 1; i <= T_LAST; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  pgt_log u_log (
    .clk   (clk),
    .en    (adv),
    .w     (b0_r.w),
    .l_out (l_val)
  );

  // ratio dividers, one quotient bit per stage
  for (genvar k = 1; k <= DS; k++) begin : g_div
    logic [WW-1:0] ra_in, rb_in, d_in;
    logic [DS-1:0] qa_in, qb_in;
    logic [WW:0]   sa, sb;
    if (k == 1) begin : g_init
      assign ra_in = b0_r.sq_a;
      assign rb_in = b0_r.sq_b;
      assign d_in  = b0_r.w;
      assign qa_in = '0;
      assign qb_in = '0;
    end else begin : g_mid
      assign ra_in = rem_a_r[k-1];
      assign rb_in = rem_b_r[k-1];
      assign d_in  = den_r[k-1];
      assign qa_in = q_a_r[k-1];
      assign qb_in = q_b_r[k-1];
    end
    assign sa = div_step(ra_in, d_in);
    assign sb = div_step(rb_in, d_in);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_a_r[k] <= sa[WW:1];
        rem_b_r[k] <= sb[WW:1];
        den_r[k]   <= d_in;
        q_a_r[k]   <= {qa_in[DS-2:0], sa[0]};
        q_b_r[k]   <= {qb_in[DS-2:0], sb[0]};
      end
    end
  end

  // align quotients with L, then t = r * L >> 19
  always_ff @(posedge clk) begin
    if (adv) begin
      qa_d1_r <= q_a_r[DS];
      qb_d1_r <= q_b_r[DS];
      qa_d2_r <= qa_d1_r;
      qb_d2_r <= qb_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [DS+LW-1:0] pa, pb;
    pa = qa_d2_r * l_val;
    pb = qb_d2_r * l_val;
    if (adv) begin
      t_a_r <= sd_r[T_PROD-1].full_a ? {l_val, 13'b0} : pa[DS+LW-1:19];
      t_b_r <= sd_r[T_PROD-1].full_b ? {l_val, 13'b0} : pb[DS+LW-1:19];
    end
  end

  assign x_a_r[T_PROD]  = {{(XW-TW){1'b0}}, t_a_r};
  assign x_b_r[T_PROD]  = {{(XW-TW){1'b0}}, t_b_r};
  assign rm_a_r[T_PROD] = '0;
  assign rm_b_r[T_PROD] = '0;
  assign rt_a_r[T_PROD] = '0;
  assign rt_b_r[T_PROD] = '0;

  // square roots, one result bit per stage
  for (genvar k = T_PROD + 1; k <= T_LAST; k++) begin : g_root
    logic [RMW+QW-1:0] na, nb;
    assign na = root_step(rm_a_r[k-1], rt_a_r[k-1], x_a_r[k-1][XW-1:XW-2]);
    assign nb = root_step(rm_b_r[k-1], rt_b_r[k-1], x_b_r[k-1][XW-1:XW-2]);
    always_ff @(posedge clk) begin
      if (adv) begin
        x_a_r[k]  <= {x_a_r[k-1][XW-3:0], 2'b00};
        x_b_r[k]  <= {x_b_r[k-1][XW-3:0], 2'b00};
        rm_a_r[k] <= na[RMW+QW-1:QW];
        rm_b_r[k] <= nb[RMW+QW-1:QW];
        rt_a_r[k] <= na[QW-1:0];
        rt_b_r[k] <= nb[QW-1:0];
      end
    end
  end

  // sign and saturation into the output register
  function automatic logic [OW-1:0] sign_sat(input logic [QW-1:0] mag,
                                             input logic          neg);
    logic [OW:0] m;
    logic [OW:0] lim;
    m   = (OW+1)'(mag);
    lim = neg ? ((OW+1)'(1) << (OW-1)) : (((OW+1)'(1) << (OW-1)) - 1'b1);
    if (m > lim) begin
      m = lim;
    end
    sign_sat = neg ? OW'(~m + 1'b1) : OW'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[T_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal_a_r     <= sign_sat(rt_a_r[T_LAST], sd_r[T_LAST].neg_a);
      normal_b_r     <= sd_r[T_LAST].keep ? sign_sat(rt_b_r[T_LAST], sd_r[T_LAST].neg_b)
                                          : '0;
      second_valid_r <= sd_r[T_LAST].keep;
    end
  end

  assign out_valid    = out_valid_r;
  assign normal_a     = normal_a_r;
  assign normal_b     = normal_b_r;
  assign second_valid = second_valid_r;

endmodule

FILE: rtl/core/polar_gaussian_transform_core.sv
// Top level of the polar-method Gaussian transform.
//
//  channel | dir | tdata (low bit up)             | tuser
//  in_     | in  | uniform_a[23:0], uniform_b     | keep_second
//  out_    | out | normal_a[23:0], normal_b       | second_valid
//
// Sustains one pair per cycle while out_ does not stall: every stage of the
// back pipeline takes a new beat each cycle that it advances. An accepted
// beat passes the squares loaded at the accepting edge, one queue write,
// the back capture register, 58 back stages (34-stage log with the 32-step
// dividers beside it, product, 23-step roots) and the output register.
// Rejected pairs leave the front and produce no beat.
// Reset is synchronous; no clearing pass. A stall at out_ holds the whole
// back pipeline; the 4-entry queue keeps the front taking beats until it fills.
`timescale 1ns / 1ps
module polar_gaussian_transform_core
  import pgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // uniform_a, uniform_b
  input  logic [0:0]  in_tuser,   // keep_second
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // normal_a, normal_b
  output logic [0:0]  out_tuser   // second_valid
);

  logic      push, q_full, pop, head_valid;
  pgt_item_t push_item, head_item;
  logic [OW-1:0] na, nb;
  logic      sv;

  pgt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .uniform_a   (in_tdata[SW-1:0]),
    .uniform_b   (in_tdata[2*SW-1:SW]),
    .keep_second (in_tuser[0]),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  pgt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  pgt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .normal_a     (na),
    .normal_b     (nb),
    .second_valid (sv)
  );

  assign out_tdata = {nb, na};
  assign out_tuser = sv;

endmodule

FILE: rtl/core/pgt_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
module pgt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a stalled beat stays
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // a stalled beat keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // an unused second sample reads as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[47:24] == 24'd0)
    else $error("unused second sample is not zero");

  // reset empties the output slot
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind polar_gaussian_transform_core pgt_checker u_pgt_checker (.*);
